@@ rtl/sorted_ready_queue_assert.svh @@
// Assertion macros used by the ready queue checker
`ifndef SORTED_READY_QUEUE_ASSERT_SVH
`define SORTED_READY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SRQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srq_pkg.sv @@
// Types and codes for the sorted ready queue
`default_nettype none

package srq_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  // Insertion order
  typedef enum logic [1:0] {
    MODE_FIFO = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_SJF  = 2'd2,
    MODE_SRTF = 2'd3
  } mode_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_FIN
  } state_e;

  // Process record; id in the low bits, matching the tdata layout
  typedef struct packed {
    logic [15:0] remain;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [7:0]  id;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);
  localparam int unsigned OCC_W = 5;

endpackage

`default_nettype wire

@@ rtl/sorted_ready_queue.sv @@
// Sorted ready queue of process records: top level with the insertion sequencer
//
// Input channel s_*: one beat is one request. s_tuser holds the kind (enqueue,
// dequeue head, peek head), s_tdata the record to enqueue. Output channel m_*:
// one beat per request, m_tuser the status, m_tdata the returned record and the
// occupancy after the request. cfg_we/cfg_wdata write the order mode; the user
// must write it only while idle, as the block itself does not enforce this.
// Records sit in a circular buffer in one memory; dequeue moves the head pointer.
// An enqueue walks the queue from the head through the memory read port and the
// key comparator, one entry per cycle, and ripples the displaced records one slot
// toward the tail through the write port, reading each entry ahead of its compare
// and ending with a tail write. One request is in work at a time; s_tready is
// high only idle. The output register holds a result while the receiver stalls,
// and the next request is accepted meanwhile; its result waits until that beat
// is taken. Reset empties the queue, sets fifo order and drops any pending result.
`default_nettype none

module sorted_ready_queue
  import srq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // proc_id, prio_in, burst_in, remain_in
  input  wire logic [1:0]  s_tuser,   // kind
  // result
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // out_id, out_prio, out_burst, out_remain,
                                      // occupancy, zero pad
  output logic [1:0]       m_tuser,   // status
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata  // order_mode
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // logical index to physical address, wrapping at DEPTH
  function automatic logic [AW-1:0] to_phys(logic [AW-1:0] base, logic [CW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(idx);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e        state, state_next;
  mode_e         mode;
  logic [CW-1:0] fill, fill_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] wr_idx, wr_idx_next;
  logic          pend, pend_next;
  logic          ins, ins_next;
  logic          deq, deq_next;
  rec_t          cand, cand_next;
  rec_t          carry, carry_next;
  rec_t          res_rec, res_rec_next;
  stat_e         res_stat, res_stat_next;
  logic          load_out;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic [AW-1:0] raddr;
  rec_t          rdata;
  logic          after;

  srq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  srq_rank u_rank (
    .mode  (mode),
    .slot  (rdata),
    .cand  (cand),
    .after (after)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      head   <= '0;
      rd_idx <= '0;
      wr_idx <= '0;
      pend   <= 1'b0;
      ins    <= 1'b0;
      deq    <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      head   <= head_next;
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      pend   <= pend_next;
      ins    <= ins_next;
      deq    <= deq_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cand     <= cand_next;
    carry    <= carry_next;
    res_rec  <= res_rec_next;
    res_stat <= res_stat_next;
  end

  // order mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FIFO;
    end else if (cfg_we) begin
      mode <= mode_e'(cfg_wdata);
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    head_next     = head;
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    pend_next     = pend;
    ins_next      = ins;
    deq_next      = deq;
    cand_next     = cand;
    carry_next    = carry;
    res_rec_next  = res_rec;
    res_stat_next = res_stat;
    load_out      = 1'b0;
    s_tready      = (state == ST_IDLE);
    we            = 1'b0;
    waddr         = to_phys(head, wr_idx);
    wdata         = cand;
    raddr         = head;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          res_rec_next  = '0;
          res_stat_next = STAT_OK;
          unique case (s_tuser)
            KIND_ENQ: begin
              if (fill == CW'(DEPTH)) begin
                res_stat_next = STAT_FULL;
                state_next    = ST_FIN;
              end else begin
                cand_next   = rec_t'(s_tdata);
                rd_idx_next = '0;
                wr_idx_next = '0;
                pend_next   = 1'b0;
                ins_next    = 1'b0;
                state_next  = ST_SCAN;
              end
            end
            KIND_DEQ, KIND_PEEK: begin
              deq_next = (s_tuser == KIND_DEQ);
              if (fill == '0) begin
                res_stat_next = STAT_EMPTY;
                state_next    = ST_FIN;
              end else begin
                // head read is issued this cycle
                state_next = ST_HEAD;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue read of the next entry
        raddr = to_phys(head, rd_idx);
        if (rd_idx != fill) begin
          rd_idx_next = rd_idx + CW'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        priority if (pend) begin
          // entry at wr_idx is back: insert, shift or pass
          wr_idx_next = wr_idx + CW'(1);
          carry_next  = rdata;
          if (ins) begin
            we    = 1'b1;
            wdata = carry;
          end else if (after) begin
            we       = 1'b1;
            wdata    = cand;
            ins_next = 1'b1;
          end
        end else if (rd_idx == fill) begin
          // tail slot gets the last displaced record or the new one
          we         = 1'b1;
          wdata      = ins ? carry : cand;
          fill_next  = fill + CW'(1);
          state_next = ST_FIN;
        end
      end

      ST_HEAD: begin
        res_rec_next = rdata;
        if (deq) begin
          head_next = to_phys(head, CW'(1));
          fill_next = fill - CW'(1);
        end
        state_next = ST_FIN;
      end

      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {3'b000, OCC_W'(fill), res_rec};
      m_tuser <= res_stat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/srq_store.sv @@
// Record memory: one write port, one registered read port
`default_nettype none

module srq_store
  import srq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire rec_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output rec_t               rdata
);

  rec_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/srq_rank.sv @@
// Key compare unit: does a queued record rank after the new one
`default_nettype none

module srq_rank
  import srq_pkg::*;
(
  input  wire mode_e mode,
  input  wire rec_t  slot,
  input  wire rec_t  cand,
  output logic       after
);

  // strict compare keeps arrival order among equal keys
  always_comb begin
    unique case (mode)
      MODE_FIFO: after = 1'b0;
      MODE_PRIO: after = (slot.prio < cand.prio);
      MODE_SJF:  after = (slot.burst > cand.burst);
      MODE_SRTF: after = (slot.remain > cand.remain);
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/srq_checker.sv @@
// Port-level checks for the sorted ready queue, bound to the top level
`default_nettype none

`include "sorted_ready_queue_assert.svh"

module srq_checker
  import srq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result beat holds
  `SRQ_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // one request in work at a time
  `SRQ_ASSERT_NXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted while busy")

  // a dropped enqueue reports a full queue
  `SRQ_ASSERT_IMP(a_full_occ, clk, rst, m_tvalid && (m_tuser == STAT_FULL), m_tdata[52:48] == OCC_W'(DEPTH) && m_tdata[47:0] == '0, "full status with wrong occupancy or record")

  // an empty report shows no records
  `SRQ_ASSERT_IMP(a_empty_occ, clk, rst, m_tvalid && (m_tuser == STAT_EMPTY), m_tdata[52:0] == '0, "empty status with records")

endmodule

bind sorted_ready_queue srq_checker #(
  .DEPTH (DEPTH)
) u_srq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
